// ===== rtl/mcmp_pkg.sv =====
package mcmp_pkg;

   localparam int CONTROLLER_COUNT_DEF = 128;
   localparam int DATA_W = 7;
   localparam int BEND_W = 14;

   localparam logic [7:0] ST_NOTE_ON_CH1 = 8'h90;
   localparam logic [7:0] ST_CC_LO       = 8'hB0;
   localparam logic [7:0] ST_CC_HI       = 8'hBF;
   localparam logic [7:0] ST_BEND_LO     = 8'hE0;
   localparam logic [7:0] ST_BEND_HI     = 8'hEF;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_NOTE_ON     = 3'd1,
      EV_NOTE_OFF    = 3'd2,
      EV_CTRL_CHANGE = 3'd3,
      EV_PITCH_BEND  = 3'd4,
      EV_READ_DATA   = 3'd5
   } event_kind_type;

   typedef enum logic {
      ACT_RX_BYTE  = 1'b0,
      ACT_READ_CTL = 1'b1
   } action_type;

   typedef struct packed {
      event_kind_type      event_kind;
      logic                voice_reset;
      logic                gate;
      logic [DATA_W-1:0]   note_number;
      logic [DATA_W-1:0]   velocity;
      logic [DATA_W-1:0]   controller_number;
      logic [DATA_W-1:0]   controller_value;
      logic [BEND_W-1:0]   bend_value;
   } rsp_payload_type;

endpackage

// ===== rtl/mcmp_req_if.sv =====
interface mcmp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

// ===== rtl/mcmp_rsp_if.sv =====
interface mcmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic        voice_reset;
   logic        gate;
   logic [6:0]  note_number;
   logic [6:0]  velocity;
   logic [6:0]  controller_number;
   logic [6:0]  controller_value;
   logic [13:0] bend_value;

   modport source (output valid, output event_kind, output voice_reset, output gate,
                   output note_number, output velocity, output controller_number,
                   output controller_value, output bend_value, input ready);
   modport sink (input valid, input event_kind, input voice_reset, input gate,
                 input note_number, input velocity, input controller_number,
                 input controller_value, input bend_value, output ready);
endinterface

// ===== rtl/mcmp_ram.sv =====
module mcmp_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/midi_channel_message_parser.sv =====
// MIDI channel message parser with running status.
// Each transaction on the req_chan channel carries one received MIDI byte
// (action 0) or a query of the controller store (action 1, controller number
// in the low seven bits). Every request transaction yields exactly one
// transaction on rsp_chan, in order, with the event kind, the gate, note,
// velocity and bend state after that byte, and the controller written or read.
// A request passes an input register and then the result register before its
// response is offered. One request is taken per cycle while rsp_chan is not
// stalled; the controller store is a RAM whose registered read is started
// as the request is accepted, and a write still in flight is forwarded
// to that read. Reset clears the parser state, the result valid bit and one
// valid bit per controller entry, so the whole store reads as zero at once;
// no clearing pass.
// When the receiver holds rsp_chan.ready low, the result register keeps its
// transaction, the input register fills once more, and then req_chan.ready
// drops until the receiver takes the waiting transaction.
module midi_channel_message_parser import mcmp_pkg::*; #(
   parameter int CONTROLLER_COUNT = CONTROLLER_COUNT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   mcmp_req_if.sink      req_chan,
   mcmp_rsp_if.source    rsp_chan
);

   localparam int CTL_AW = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;

   logic                     req_accept;
   logic                     s1_advance;
   logic                     s1_valid_ff;
   logic                     s1_action_ff;
   logic [7:0]               s1_byte_ff;
   logic                     fwd_hit_ff;
   logic [DATA_W-1:0]        fwd_data_ff;
   logic                     rd_valid_ff;
   logic [CONTROLLER_COUNT-1:0] ctl_valid_ff;

   logic [7:0]               status_latch_ff, status_latch_in;
   logic                     data_phase_ff, data_phase_in;
   logic [DATA_W-1:0]        first_data_ff, first_data_in;
   logic                     gate_ff, gate_in;
   logic [DATA_W-1:0]        held_note_ff, held_note_in;
   logic [DATA_W-1:0]        held_velocity_ff, held_velocity_in;
   logic [BEND_W-1:0]        bend_ff, bend_in;

   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic                     ctl_wr_en;
   logic [CTL_AW-1:0]        ctl_wr_addr;
   logic [CTL_AW-1:0]        ctl_rd_addr;
   logic [DATA_W-1:0]        ctl_rd_data;
   logic [DATA_W-1:0]        ctl_read_value;

   function automatic logic ctl_in_range(input logic [DATA_W-1:0] num);
      return {1'b0, num} < 8'(CONTROLLER_COUNT);
   endfunction

   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign ctl_rd_addr    = req_chan.rx_byte[CTL_AW-1:0];
   assign ctl_wr_addr    = first_data_ff[CTL_AW-1:0];
   assign ctl_wr_en      = s1_advance && (rsp_payload_in.event_kind == EV_CTRL_CHANGE)
                           && ctl_in_range(first_data_ff);

   assign ctl_read_value = fwd_hit_ff  ? fwd_data_ff :
                           rd_valid_ff ? ctl_rd_data : '0;

   mcmp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CONTROLLER_COUNT)
   ) u_ctl_store (
      .clock   (clock),
      .wr_en   (ctl_wr_en),
      .wr_addr (ctl_wr_addr),
      .wr_data (s1_byte_ff[DATA_W-1:0]),
      .rd_en   (req_accept),
      .rd_addr (ctl_rd_addr),
      .rd_data (ctl_rd_data)
   );

   always_comb begin
      status_latch_in  = status_latch_ff;
      data_phase_in    = data_phase_ff;
      first_data_in    = first_data_ff;
      gate_in          = gate_ff;
      held_note_in     = held_note_ff;
      held_velocity_in = held_velocity_ff;
      bend_in          = bend_ff;
      rsp_payload_in   = '0;
      rsp_payload_in.event_kind = EV_NONE;

      if (s1_action_ff == ACT_READ_CTL) begin
         rsp_payload_in.event_kind        = EV_READ_DATA;
         rsp_payload_in.controller_number = s1_byte_ff[DATA_W-1:0];
         rsp_payload_in.controller_value  =
            ctl_in_range(s1_byte_ff[DATA_W-1:0]) ? ctl_read_value : '0;
      end else if (s1_byte_ff[7]) begin
         status_latch_in = s1_byte_ff;
         data_phase_in   = 1'b0;
      end else if (!data_phase_ff) begin
         first_data_in = s1_byte_ff[DATA_W-1:0];
         data_phase_in = 1'b1;
      end else begin
         data_phase_in = 1'b0;
         if (status_latch_ff == ST_NOTE_ON_CH1) begin
            if (s1_byte_ff[DATA_W-1:0] == '0) begin
               gate_in = 1'b0;
               rsp_payload_in.event_kind = EV_NOTE_OFF;
            end else begin
               rsp_payload_in.voice_reset = !gate_ff;
               held_velocity_in = s1_byte_ff[DATA_W-1:0];
               held_note_in     = first_data_ff;
               gate_in          = 1'b1;
               rsp_payload_in.event_kind = EV_NOTE_ON;
            end
         end else if (status_latch_ff >= ST_CC_LO && status_latch_ff <= ST_CC_HI) begin
            rsp_payload_in.event_kind        = EV_CTRL_CHANGE;
            rsp_payload_in.controller_number = first_data_ff;
            rsp_payload_in.controller_value  = s1_byte_ff[DATA_W-1:0];
         end else if (status_latch_ff >= ST_BEND_LO && status_latch_ff <= ST_BEND_HI) begin
            bend_in = {s1_byte_ff[DATA_W-1:0], first_data_ff};
            rsp_payload_in.event_kind = EV_PITCH_BEND;
         end
      end

      rsp_payload_in.gate        = gate_in;
      rsp_payload_in.note_number = held_note_in;
      rsp_payload_in.velocity    = held_velocity_in;
      rsp_payload_in.bend_value  = bend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         ctl_valid_ff     <= '0;
         status_latch_ff  <= '0;
         data_phase_ff    <= 1'b0;
         first_data_ff    <= '0;
         gate_ff          <= 1'b0;
         held_note_ff     <= '0;
         held_velocity_ff <= '0;
         bend_ff          <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_advance) begin
            rsp_valid_ff     <= 1'b1;
            status_latch_ff  <= status_latch_in;
            data_phase_ff    <= data_phase_in;
            first_data_ff    <= first_data_in;
            gate_ff          <= gate_in;
            held_note_ff     <= held_note_in;
            held_velocity_ff <= held_velocity_in;
            bend_ff          <= bend_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (ctl_wr_en) begin
            ctl_valid_ff[ctl_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_chan.action;
         s1_byte_ff   <= req_chan.rx_byte;
         fwd_hit_ff   <= ctl_wr_en && (ctl_wr_addr == ctl_rd_addr);
         fwd_data_ff  <= s1_byte_ff[DATA_W-1:0];
         rd_valid_ff  <= ctl_valid_ff[ctl_rd_addr];
      end
      if (s1_advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.event_kind        = rsp_payload_ff.event_kind;
   assign rsp_chan.voice_reset       = rsp_payload_ff.voice_reset;
   assign rsp_chan.gate              = rsp_payload_ff.gate;
   assign rsp_chan.note_number       = rsp_payload_ff.note_number;
   assign rsp_chan.velocity          = rsp_payload_ff.velocity;
   assign rsp_chan.controller_number = rsp_payload_ff.controller_number;
   assign rsp_chan.controller_value  = rsp_payload_ff.controller_value;
   assign rsp_chan.bend_value        = rsp_payload_ff.bend_value;

endmodule

// ===== test/tb_midi_channel_message_parser.sv =====
`timescale 1ns / 1ps

module tb_midi_channel_message_parser;
   import mcmp_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      action_type action;
      logic [7:0] rx_byte;
      logic [1:0] phase;
      logic       drain;
   } midi_item_type;

   logic clock = 1'b0;
   logic reset;

   mcmp_req_if req_bus ();
   mcmp_rsp_if rsp_bus ();

   midi_channel_message_parser dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #4 clock = ~clock;

   midi_item_type   byte_stream[$];
   rsp_payload_type expected_events[$];

   int unsigned send_idle_pct[4] = '{0, 78, 0, 17};
   int unsigned recv_stall_pct[4] = '{0, 0, 78, 17};

   logic [1:0] fill_phase = 2'd0;
   logic       drain_next = 1'b0;
   logic [1:0] drive_phase = 2'd0;
   int         accepted_count = 0;
   int         item_total = 0;
   int         error_count = 0;
   int         quiet_cycles = 0;

   // Parser state as the block should hold it.
   logic [7:0] status_q = 8'd0;
   logic       second_half = 1'b0;
   logic [6:0] first_q = 7'd0;
   logic       gate_q = 1'b0;
   logic [6:0] note_q = 7'd0;
   logic [6:0] vel_q = 7'd0;
   logic [13:0] bend_q = 14'd0;
   logic [6:0] ctl_mem[0:127] = '{default: 7'd0};

   task automatic parse_midi_item(input action_type act, input logic [7:0] b);
      rsp_payload_type ev;
      ev = '0;
      ev.event_kind = EV_NONE;
      if (act == ACT_READ_CTL) begin
         ev.event_kind = EV_READ_DATA;
         ev.controller_number = b[6:0];
         ev.controller_value = (b[6:0] < CONTROLLER_COUNT_DEF) ? ctl_mem[b[6:0]] : 7'd0;
      end else if (b[7]) begin
         status_q = b;
         second_half = 1'b0;
      end else if (!second_half) begin
         first_q = b[6:0];
         second_half = 1'b1;
      end else begin
         second_half = 1'b0;
         if (status_q == ST_NOTE_ON_CH1) begin
            if (b == 8'd0) begin
               gate_q = 1'b0;
               ev.event_kind = EV_NOTE_OFF;
            end else begin
               ev.voice_reset = !gate_q;
               vel_q = b[6:0];
               note_q = first_q;
               gate_q = 1'b1;
               ev.event_kind = EV_NOTE_ON;
            end
         end else if (status_q >= ST_CC_LO && status_q <= ST_CC_HI) begin
            ev.controller_number = first_q;
            ev.controller_value = b[6:0];
            if (first_q < CONTROLLER_COUNT_DEF) ctl_mem[first_q] = b[6:0];
            ev.event_kind = EV_CTRL_CHANGE;
         end else if (status_q >= ST_BEND_LO && status_q <= ST_BEND_HI) begin
            bend_q = {b[6:0], first_q};
            ev.event_kind = EV_PITCH_BEND;
         end
      end
      ev.gate = gate_q;
      ev.note_number = note_q;
      ev.velocity = vel_q;
      ev.bend_value = bend_q;
      expected_events.push_back(ev);
   endtask

   function automatic string describe_event(input rsp_payload_type e);
      return $sformatf("kind %0d reset %0b gate %0b note %0d vel %0d ctl %0d val %0d bend %0d",
                       e.event_kind, e.voice_reset, e.gate, e.note_number, e.velocity,
                       e.controller_number, e.controller_value, e.bend_value);
   endfunction

   task automatic push_item(input action_type act, input logic [7:0] b);
      midi_item_type item;
      item.action = act;
      item.rx_byte = b;
      item.phase = fill_phase;
      item.drain = drain_next;
      byte_stream.push_back(item);
      drain_next = 1'b0;
   endtask

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h7F;
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   // Favors a few controller numbers at both ends so that reads find written entries.
   function automatic logic [6:0] pick_controller();
      case ($urandom_range(0, 3))
         0: return 7'($urandom_range(0, 7));
         1: return 7'($urandom_range(120, 127));
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.action <= ACT_RX_BYTE;
         req_bus.rx_byte <= 8'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_midi_item(action_type'(req_bus.action), req_bus.rx_byte);
            accepted_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_stream.size() != 0
                && !(byte_stream[0].drain && expected_events.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct[byte_stream[0].phase]) begin
               drive_phase <= byte_stream[0].phase;
               req_bus.valid <= 1'b1;
               req_bus.action <= byte_stream[0].action;
               req_bus.rx_byte <= byte_stream[0].rx_byte;
               void'(byte_stream.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type seen;
      rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.event_kind = event_kind_type'(rsp_bus.event_kind);
            seen.voice_reset = rsp_bus.voice_reset;
            seen.gate = rsp_bus.gate;
            seen.note_number = rsp_bus.note_number;
            seen.velocity = rsp_bus.velocity;
            seen.controller_number = rsp_bus.controller_number;
            seen.controller_value = rsp_bus.controller_value;
            seen.bend_value = rsp_bus.bend_value;
            if (expected_events.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected response transaction: %s", describe_event(seen));
               error_count++;
            end else begin
               want = expected_events.pop_front();
               if (seen !== want) begin
                  if (error_count < 10)
                     $display("response mismatch: expected %s, got %s",
                              describe_event(want), describe_event(seen));
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= $urandom_range(0, 99) >= recv_stall_pct[drive_phase];
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("midi_channel_message_parser test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int         r;
      int         pairs;
      int         directed_count;
      logic [7:0] st;
      logic [7:0] b;

      reset = 1'b1;

      // Directed opening: status zero after reset, note on and off, other channels,
      // controller extremes, a read with the top bit set, bend extremes, broken pairs.
      push_item(ACT_READ_CTL, 8'hFF);
      push_item(ACT_RX_BYTE, 8'h00); push_item(ACT_RX_BYTE, 8'h7F);
      push_item(ACT_RX_BYTE, ST_NOTE_ON_CH1); push_item(ACT_RX_BYTE, 8'h3C);
      push_item(ACT_RX_BYTE, 8'h7F);
      push_item(ACT_RX_BYTE, 8'h7F); push_item(ACT_RX_BYTE, 8'h01);
      push_item(ACT_RX_BYTE, 8'h40); push_item(ACT_RX_BYTE, 8'h00);
      push_item(ACT_RX_BYTE, 8'h91); push_item(ACT_RX_BYTE, 8'h22); push_item(ACT_RX_BYTE, 8'h33);
      push_item(ACT_RX_BYTE, ST_CC_HI); push_item(ACT_RX_BYTE, 8'h7F);
      push_item(ACT_RX_BYTE, 8'h7F); push_item(ACT_RX_BYTE, 8'h00); push_item(ACT_RX_BYTE, 8'h55);
      push_item(ACT_READ_CTL, 8'h7F);
      push_item(ACT_RX_BYTE, ST_BEND_HI); push_item(ACT_RX_BYTE, 8'h7F);
      push_item(ACT_RX_BYTE, 8'h7F);
      push_item(ACT_RX_BYTE, 8'hE5); push_item(ACT_RX_BYTE, 8'h10);
      push_item(ACT_RX_BYTE, ST_NOTE_ON_CH1); push_item(ACT_RX_BYTE, 8'h20);
      push_item(ACT_RX_BYTE, 8'h30);
      directed_count = byte_stream.size();

      for (int p = 0; p < 8; p++) begin
         fill_phase = 2'(p % 4);
         drain_next = 1'b1;
         while (byte_stream.size() < directed_count + (p + 1) * 205) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: st = ST_NOTE_ON_CH1;
                  4: st = 8'($urandom_range(8'h91, 8'h9F));
                  5, 6: st = 8'($urandom_range(ST_CC_LO, ST_CC_HI));
                  7, 8: st = 8'($urandom_range(ST_BEND_LO, ST_BEND_HI));
                  default: st = 8'($urandom_range(128, 255));
               endcase
               push_item(ACT_RX_BYTE, st);
               pairs = $urandom_range(1, 4);
               for (int k = 0; k < pairs; k++) begin
                  if (st >= ST_CC_LO && st <= ST_CC_HI && $urandom_range(0, 1) == 1)
                     push_item(ACT_RX_BYTE, {1'b0, pick_controller()});
                  else
                     push_item(ACT_RX_BYTE, pick_data());
                  if ($urandom_range(0, 9) == 0) begin
                     b = 8'($urandom_range(0, 255));
                     b[6:0] = pick_controller();
                     push_item(ACT_READ_CTL, b);
                  end
                  if (st == ST_NOTE_ON_CH1 && $urandom_range(0, 4) == 0)
                     push_item(ACT_RX_BYTE, 8'h00);
                  else
                     push_item(ACT_RX_BYTE, pick_data());
               end
            end else if (r < 80) begin
               b = 8'($urandom_range(0, 255));
               b[6:0] = pick_controller();
               push_item(ACT_READ_CTL, b);
            end else if (r < 92) begin
               push_item(ACT_RX_BYTE, 8'($urandom_range(0, 255)));
            end else begin
               push_item(ACT_RX_BYTE, 8'($urandom_range(128, 255)));
               push_item(ACT_RX_BYTE, pick_data());
            end
         end
      end
      item_total = byte_stream.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < item_total || expected_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      error_count += expected_events.size();
      if (error_count == 0)
         $display("midi_channel_message_parser test passed");
      else
         $display("midi_channel_message_parser test failed");
      $finish;
   end

endmodule
